FILE: design/rpp_pkg.sv
// Shared widths, register codes, limits and result type for rotate_project_point.
package rpp_pkg;

  localparam int COORD_W         = 16;
  localparam int TRIG_W          = 16;
  localparam int TRIG_FRAC       = 14;
  localparam int FOV_W           = 10;
  localparam int QUOT_W          = 16;
  localparam int NUM_W           = 48;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 16;
  localparam int COORD_FRAC_DEF  = 4;

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_YAW_SIN   = 3'd0,
    REG_YAW_COS   = 3'd1,
    REG_PITCH_SIN = 3'd2,
    REG_PITCH_COS = 3'd3,
    REG_VIEW_DIST = 3'd4
  } cfg_reg_t;

  // Register reset values
  localparam logic signed [TRIG_W-1:0] YAW_SIN_RST   = -16'sd14648;
  localparam logic signed [TRIG_W-1:0] YAW_COS_RST   = -16'sd7342;
  localparam logic signed [TRIG_W-1:0] PITCH_SIN_RST = 16'sd0;
  localparam logic signed [TRIG_W-1:0] PITCH_COS_RST = 16'sd16384;
  localparam logic [FOV_W-1:0]         VIEW_DIST_RST = 10'd175;

  // Saturation codes and quotient limits
  localparam logic [COORD_W-1:0] SAT_MAX   = 16'h7FFF;
  localparam logic [COORD_W-1:0] SAT_MIN   = 16'h8000;
  localparam logic [QUOT_W-1:0]  POS_LIMIT = 16'h7FFF;
  localparam logic [QUOT_W-1:0]  NEG_LIMIT = 16'h8000;

  // Width of the signed denominator for a given number of fraction bits
  function automatic int den_width(input int frac_bits);
    den_width = (frac_bits + 40 > 49) ? frac_bits + 40 : 49;
  endfunction

  typedef struct packed {
    logic                        div_by_zero;
    logic signed [COORD_W-1:0]   screen_y;
    logic signed [COORD_W-1:0]   screen_x;
  } rpp_result_t;

endpackage

FILE: design/rotate_project_point.sv
// Top level of rotate_project_point: config registers, front end, divider, output buffer.
//
//  port group   dir  fields (low bit first)                 notes
//  s_axis       in   tdata: x_pos, y_pos, z_pos             48 bits
//  m_axis       out  tdata: screen_x, screen_y; tuser: dbz   32 + 1 bits
//  cfg          in   cfg_index 0..4, cfg_data 16 bits       write only
//
//  One item per cycle sustained while the skid stage stays empty.
//  The path runs through 4 rotation stages, 4 scaling stages, the 16 stage restoring
//  divider (one quotient bit per stage) and the output register (25 stages).
//  Reset clears all valid bits and loads the default view registers.
//  When m_tready stays low, one more item lands in the skid stage, then the
//  whole pipeline and s_tready hold until the skid drains.
module rotate_project_point #(
  parameter int COORD_FRAC_BITS = rpp_pkg::COORD_FRAC_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [3*rpp_pkg::COORD_W-1:0]      s_tdata,   // x_pos, y_pos, z_pos
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [2*rpp_pkg::COORD_W-1:0]      m_tdata,   // screen_x, screen_y
  output logic                               m_tuser,   // div_by_zero
  input  logic                               cfg_we,
  input  logic [rpp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rpp_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import rpp_pkg::*;

  localparam int DEN_W = den_width(COORD_FRAC_BITS);

  logic signed [TRIG_W-1:0] yaw_sin, yaw_cos, pitch_sin, pitch_cos;
  logic [FOV_W-1:0]         view_distance;

  logic                     en;
  logic                     fr_valid;
  logic signed [NUM_W-1:0]  num_x, num_y;
  logic signed [DEN_W-1:0]  den;
  logic                     dv_valid;
  rpp_result_t              dv_result;
  rpp_result_t              ob_data;

  // Write view registers; other indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      yaw_sin       <= YAW_SIN_RST;
      yaw_cos       <= YAW_COS_RST;
      pitch_sin     <= PITCH_SIN_RST;
      pitch_cos     <= PITCH_COS_RST;
      view_distance <= VIEW_DIST_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_YAW_SIN:   yaw_sin       <= cfg_data;
        REG_YAW_COS:   yaw_cos       <= cfg_data;
        REG_PITCH_SIN: pitch_sin     <= cfg_data;
        REG_PITCH_COS: pitch_cos     <= cfg_data;
        REG_VIEW_DIST: view_distance <= cfg_data[FOV_W-1:0];
        default: ;
      endcase
    end
  end

  assign s_tready = en;

  rpp_front #(
    .COORD_FRAC_BITS (COORD_FRAC_BITS),
    .DEN_W           (DEN_W)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .en            (en),
    .in_valid      (s_tvalid),
    .x_pos         (s_tdata[COORD_W-1:0]),
    .y_pos         (s_tdata[2*COORD_W-1:COORD_W]),
    .z_pos         (s_tdata[3*COORD_W-1:2*COORD_W]),
    .yaw_sin       (yaw_sin),
    .yaw_cos       (yaw_cos),
    .pitch_sin     (pitch_sin),
    .pitch_cos     (pitch_cos),
    .view_distance (view_distance),
    .out_valid     (fr_valid),
    .num_x         (num_x),
    .num_y         (num_y),
    .den           (den)
  );

  rpp_div #(
    .COORD_FRAC_BITS (COORD_FRAC_BITS),
    .DEN_W           (DEN_W)
  ) u_div (
    .clk           (clk),
    .rst           (rst),
    .en            (en),
    .in_valid      (fr_valid),
    .num_x         (num_x),
    .num_y         (num_y),
    .den           (den),
    .view_distance (view_distance),
    .out_valid     (dv_valid),
    .result        (dv_result)
  );

  rpp_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dv_valid),
    .in_data   (dv_result),
    .en        (en),
    .out_valid (m_tvalid),
    .out_data  (ob_data),
    .out_ready (m_tready)
  );

  assign m_tdata = {ob_data.screen_y, ob_data.screen_x};
  assign m_tuser = ob_data.div_by_zero;

endmodule

FILE: design/rpp_front.sv
// Rotation front end: products and sums that form both numerators and the denominator.
module rpp_front #(
  parameter int COORD_FRAC_BITS = rpp_pkg::COORD_FRAC_DEF,
  parameter int DEN_W           = rpp_pkg::den_width(COORD_FRAC_BITS)
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     en,
  input  logic                                     in_valid,
  input  logic signed [rpp_pkg::COORD_W-1:0]       x_pos,
  input  logic signed [rpp_pkg::COORD_W-1:0]       y_pos,
  input  logic signed [rpp_pkg::COORD_W-1:0]       z_pos,
  input  logic signed [rpp_pkg::TRIG_W-1:0]        yaw_sin,
  input  logic signed [rpp_pkg::TRIG_W-1:0]        yaw_cos,
  input  logic signed [rpp_pkg::TRIG_W-1:0]        pitch_sin,
  input  logic signed [rpp_pkg::TRIG_W-1:0]        pitch_cos,
  input  logic [rpp_pkg::FOV_W-1:0]                view_distance,
  output logic                                     out_valid,
  output logic signed [rpp_pkg::NUM_W-1:0]         num_x,
  output logic signed [rpp_pkg::NUM_W-1:0]         num_y,
  output logic signed [DEN_W-1:0]                  den
);
  import rpp_pkg::*;

  localparam int PROD_W = COORD_W + TRIG_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int WIDE_W = SUM_W + TRIG_W;

  logic v1, v2, v3;

  logic signed [PROD_W-1:0] cyy1, syx1, cyx1, syy1, spz1, cpz1;
  logic signed [SUM_W-1:0]  u2, w2;
  logic signed [PROD_W-1:0] spz2, cpz2;
  logic signed [WIDE_W-1:0] usp3, ucp3;
  logic signed [NUM_W-1:0]  ny3;
  logic signed [PROD_W-1:0] spz3, cpz3;

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
  end

  // Stage 1: coordinate by trig products
  always_ff @(posedge clk) begin
    if (en) begin
      cyy1 <= PROD_W'(yaw_cos) * PROD_W'(y_pos);
      syx1 <= PROD_W'(yaw_sin) * PROD_W'(x_pos);
      cyx1 <= PROD_W'(yaw_cos) * PROD_W'(x_pos);
      syy1 <= PROD_W'(yaw_sin) * PROD_W'(y_pos);
      spz1 <= PROD_W'(pitch_sin) * PROD_W'(z_pos);
      cpz1 <= PROD_W'(pitch_cos) * PROD_W'(z_pos);
    end
  end

  // Stage 2: yaw rotation sums
  always_ff @(posedge clk) begin
    if (en) begin
      u2   <= SUM_W'(cyy1) + SUM_W'(syx1);
      w2   <= SUM_W'(cyx1) - SUM_W'(syy1);
      spz2 <= spz1;
      cpz2 <= cpz1;
    end
  end

  // Stage 3: pitch products of the rotated term
  always_ff @(posedge clk) begin
    if (en) begin
      usp3 <= WIDE_W'(u2) * WIDE_W'(pitch_sin);
      ucp3 <= WIDE_W'(u2) * WIDE_W'(pitch_cos);
      ny3  <= NUM_W'(w2) <<< TRIG_FRAC;
      spz3 <= spz2;
      cpz3 <= cpz2;
    end
  end

  // Stage 4: align to common scale and sum
  always_ff @(posedge clk) begin
    if (en) begin
      den   <= DEN_W'(usp3)
             + (DEN_W'(view_distance) << (COORD_FRAC_BITS + 2 * TRIG_FRAC))
             - (DEN_W'(cpz3) <<< TRIG_FRAC);
      num_x <= (NUM_W'(spz3) <<< TRIG_FRAC) + NUM_W'(ucp3);
      num_y <= ny3;
    end
  end

endmodule

FILE: design/rpp_div.sv
// Two-lane pipelined restoring divider with rounding, sign and saturation.
module rpp_div #(
  parameter int COORD_FRAC_BITS = rpp_pkg::COORD_FRAC_DEF,
  parameter int DEN_W           = rpp_pkg::den_width(COORD_FRAC_BITS)
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  logic                               in_valid,
  input  logic signed [rpp_pkg::NUM_W-1:0]   num_x,
  input  logic signed [rpp_pkg::NUM_W-1:0]   num_y,
  input  logic signed [DEN_W-1:0]            den,
  input  logic [rpp_pkg::FOV_W-1:0]          view_distance,
  output logic                               out_valid,
  output rpp_pkg::rpp_result_t               result
);
  import rpp_pkg::*;

  localparam int A_W   = NUM_W + FOV_W + COORD_FRAC_BITS;
  localparam int N_W   = A_W + 1;
  localparam int CMP_W = (N_W > DEN_W + QUOT_W) ? N_W : DEN_W + QUOT_W;
  localparam int NSTG  = QUOT_W;

  typedef struct packed {
    logic       dz;
    logic       den_neg;
    logic [1:0] num_neg;
    logic [1:0] num_nz;
    logic [1:0] ovf;
  } flags_t;

  logic signed [NUM_W-1:0] num [2];
  assign num[0] = num_x;
  assign num[1] = num_y;

  logic             v1, v2, v3;
  logic [NUM_W-1:0] mag1 [2];
  logic [A_W-1:0]   a2 [2];
  logic [N_W-1:0]   n3 [2];
  logic [DEN_W-1:0] b1, b2, b3;
  flags_t           fl1, fl2, fl3, flags0;
  logic [1:0]       ovf0;

  logic             vq   [NSTG+1];
  logic [N_W-1:0]   rem  [NSTG+1][2];
  logic [QUOT_W-1:0] quo [NSTG+1][2];
  logic [DEN_W-1:0] bq   [NSTG+1];
  flags_t           fq   [NSTG+1];

  logic [CMP_W-1:0] sub_val [NSTG];
  logic             take    [NSTG][2];
  logic [CMP_W-1:0] diff    [NSTG][2];

  logic [COORD_W-1:0] res [2];

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      for (int s = 0; s <= NSTG; s++) vq[s] <= 1'b0;
    end else if (en) begin
      v1    <= in_valid;
      v2    <= v1;
      v3    <= v2;
      vq[0] <= v3;
      for (int s = 0; s < NSTG; s++) vq[s+1] <= vq[s];
    end
  end

  // D1: magnitudes and sign flags
  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 2; l++) begin
        mag1[l]        <= num[l][NUM_W-1] ? NUM_W'(-num[l]) : NUM_W'(num[l]);
        fl1.num_neg[l] <= num[l][NUM_W-1];
        fl1.num_nz[l]  <= |num[l];
      end
      b1          <= den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
      fl1.den_neg <= den[DEN_W-1];
      fl1.dz      <= (den == '0);
      fl1.ovf     <= 2'b00;
    end
  end

  // D2: scale dividend by view distance and fraction bits
  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 2; l++) begin
        a2[l] <= (A_W'(mag1[l]) * A_W'(view_distance)) << COORD_FRAC_BITS;
      end
      b2  <= b1;
      fl2 <= fl1;
    end
  end

  // D3: add half the divisor for round to nearest
  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 2; l++) begin
        n3[l] <= N_W'(a2[l]) + N_W'(b2 >> 1);
      end
      b3  <= b2;
      fl3 <= fl2;
    end
  end

  // Quotient beyond the output range saturates
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      ovf0[l] = CMP_W'(n3[l]) >= (CMP_W'(b3) << QUOT_W);
    end
    flags0     = fl3;
    flags0.ovf = ovf0;
  end

  // Trial subtract for each quotient bit, most significant first
  always_comb begin
    for (int s = 0; s < NSTG; s++) begin
      sub_val[s] = CMP_W'(bq[s]) << (NSTG - 1 - s);
      for (int l = 0; l < 2; l++) begin
        take[s][l] = CMP_W'(rem[s][l]) >= sub_val[s];
        diff[s][l] = CMP_W'(rem[s][l]) - sub_val[s];
      end
    end
  end

  // Divider stages: load, then one quotient bit per stage
  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 2; l++) begin
        rem[0][l] <= n3[l];
        quo[0][l] <= '0;
      end
      bq[0] <= b3;
      fq[0] <= flags0;
      for (int s = 0; s < NSTG; s++) begin
        for (int l = 0; l < 2; l++) begin
          rem[s+1][l] <= take[s][l] ? N_W'(diff[s][l]) : rem[s][l];
          quo[s+1][l] <= quo[s][l]
                       | (take[s][l] ? (QUOT_W'(1) << (NSTG - 1 - s)) : '0);
        end
        bq[s+1] <= bq[s];
        fq[s+1] <= fq[s];
      end
    end
  end

  // Apply sign, saturate, and handle a zero denominator
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      if (fq[NSTG].dz) begin
        if (!fq[NSTG].num_nz[l]) begin
          res[l] = '0;
        end else if (fq[NSTG].num_neg[l]) begin
          res[l] = SAT_MIN;
        end else begin
          res[l] = SAT_MAX;
        end
      end else if (fq[NSTG].num_neg[l] ^ fq[NSTG].den_neg) begin
        if (fq[NSTG].ovf[l] || (quo[NSTG][l] > NEG_LIMIT)) begin
          res[l] = SAT_MIN;
        end else begin
          res[l] = COORD_W'(~quo[NSTG][l] + 1'b1);
        end
      end else begin
        if (fq[NSTG].ovf[l] || (quo[NSTG][l] > POS_LIMIT)) begin
          res[l] = SAT_MAX;
        end else begin
          res[l] = COORD_W'(quo[NSTG][l]);
        end
      end
    end
  end

  assign out_valid          = vq[NSTG];
  assign result.screen_x    = res[0];
  assign result.screen_y    = res[1];
  assign result.div_by_zero = fq[NSTG].dz;

  // A zero denominator always flags both lanes for saturation
  a_dz_ovf: assert property (@(posedge clk) disable iff (rst)
    (vq[0] && fq[0].dz) |-> (fq[0].ovf == 2'b11))
    else $error("zero denominator without saturation flags");

  // Remainder ends below the divisor when the quotient fits
  a_rem_x: assert property (@(posedge clk) disable iff (rst)
    (vq[NSTG] && !fq[NSTG].dz && !fq[NSTG].ovf[0])
      |-> (CMP_W'(rem[NSTG][0]) < CMP_W'(bq[NSTG])))
    else $error("x remainder not below divisor");

  a_rem_y: assert property (@(posedge clk) disable iff (rst)
    (vq[NSTG] && !fq[NSTG].dz && !fq[NSTG].ovf[1])
      |-> (CMP_W'(rem[NSTG][1]) < CMP_W'(bq[NSTG])))
    else $error("y remainder not below divisor");

endmodule

FILE: design/rpp_outbuf.sv
// Output register with a skid stage; freezes the pipeline while the skid is full.
module rpp_outbuf (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  rpp_pkg::rpp_result_t  in_data,
  output logic                  en,
  output logic                  out_valid,
  output rpp_pkg::rpp_result_t  out_data,
  input  logic                  out_ready
);
  import rpp_pkg::*;

  logic        skid_valid;
  rpp_result_t skid_data;
  logic        take;
  logic        incoming;

  assign en       = !skid_valid;
  assign take     = out_valid && out_ready;
  assign incoming = en && in_valid;

  // Refill the output register from the skid first, else from the pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || take) begin
      out_valid  <= skid_valid || incoming;
      skid_valid <= 1'b0;
    end else if (incoming) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || take) begin
      out_data <= skid_valid ? skid_data : in_data;
    end else if (incoming) begin
      skid_data <= in_data;
    end
  end

  // Skid holds an item only behind a held output item
  a_skid_behind: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid item without output item");

  // An item arriving at a stalled output lands in the skid
  a_skid_catch: assert property (@(posedge clk) disable iff (rst)
    (incoming && out_valid && !out_ready) |=> skid_valid)
    else $error("item dropped at stalled output");

endmodule

FILE: dv/rpp_checker.sv
// Checker for rotate_project_point: tracks the view registers, predicts and compares results.
`timescale 1ns / 100ps

module rpp_checker #(
  parameter int COORD_FRAC_BITS = rpp_pkg::COORD_FRAC_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [3*rpp_pkg::COORD_W-1:0]  s_tdata,   // x_pos, y_pos, z_pos
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [2*rpp_pkg::COORD_W-1:0]  m_tdata,   // screen_x, screen_y
  input  logic                           m_tuser,   // div_by_zero
  input  logic                           cfg_we,
  input  logic [rpp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rpp_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             mismatches,
  output int                             pending,
  output int                             checked,
  output int                             zero_den_hits
);
  import rpp_pkg::*;

  // Local copy of the view registers
  logic signed [TRIG_W-1:0] yaw_sin, yaw_cos, pitch_sin, pitch_cos;
  logic [FOV_W-1:0]         view_dist;

  // Projections still waiting for their result item
  rpp_result_t projected_q[$];

  // Round |num|*fov*2^F / |den| to nearest, apply the sign, saturate to 16 bits
  function automatic logic [COORD_W-1:0] scale_quotient(input longint num, input longint den,
                                                        input longint unsigned fov);
    longint unsigned num_mag, den_mag, quot;
    if (den == 0) begin
      if (num > 0) return SAT_MAX;
      if (num < 0) return SAT_MIN;
      return '0;
    end
    num_mag = (num < 0) ? longint'(0) - num : num;
    den_mag = (den < 0) ? longint'(0) - den : den;
    quot = ((num_mag * fov) << COORD_FRAC_BITS);
    quot = (quot + den_mag / 2) / den_mag;
    if ((num < 0) != (den < 0)) begin
      if (quot > 32768) quot = 32768;
      return COORD_W'(longint'(0) - longint'(quot));
    end
    if (quot > 32767) quot = 32767;
    return COORD_W'(quot);
  endfunction

  // Rotate by yaw and pitch, then divide by the perspective denominator
  function automatic rpp_result_t project_point(input logic signed [COORD_W-1:0] xp,
                                                input logic signed [COORD_W-1:0] yp,
                                                input logic signed [COORD_W-1:0] zp);
    longint x, y, z, sy, cy, sp, cp, fov, trig_one, u, den, nx, ny;
    rpp_result_t res;
    x = xp;
    y = yp;
    z = zp;
    sy = yaw_sin;
    cy = yaw_cos;
    sp = pitch_sin;
    cp = pitch_cos;
    fov = longint'(view_dist);
    trig_one = longint'(1) << TRIG_FRAC;
    u = cy * y + sy * x;
    den = u * sp + (fov << (COORD_FRAC_BITS + 2 * TRIG_FRAC)) - cp * z * trig_one;
    nx = sp * z * trig_one + u * cp;
    ny = (cy * x - sy * y) * trig_one;
    res.screen_x = scale_quotient(nx, den, fov);
    res.screen_y = scale_quotient(ny, den, fov);
    res.div_by_zero = (den == 0);
    return res;
  endfunction

  // Follow register writes, check results, queue predictions
  always @(posedge clk) begin
    rpp_result_t want, got;
    if (rst) begin
      yaw_sin = YAW_SIN_RST;
      yaw_cos = YAW_COS_RST;
      pitch_sin = PITCH_SIN_RST;
      pitch_cos = PITCH_COS_RST;
      view_dist = VIEW_DIST_RST;
      projected_q.delete();
      mismatches = 0;
      checked = 0;
      zero_den_hits = 0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_YAW_SIN:   yaw_sin = cfg_data;
          REG_YAW_COS:   yaw_cos = cfg_data;
          REG_PITCH_SIN: pitch_sin = cfg_data;
          REG_PITCH_COS: pitch_cos = cfg_data;
          REG_VIEW_DIST: view_dist = cfg_data[FOV_W-1:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        got.screen_x = m_tdata[COORD_W-1:0];
        got.screen_y = m_tdata[2*COORD_W-1:COORD_W];
        got.div_by_zero = m_tuser;
        if (projected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%t: result item with no point pending: x=%0d y=%0d dbz=%0b",
                     $realtime, got.screen_x, got.screen_y, got.div_by_zero);
        end else begin
          want = projected_q.pop_front();
          checked++;
          if (want.div_by_zero) zero_den_hits++;
          if (got != want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%t: mismatch exp x=%0d y=%0d dbz=%0b, got x=%0d y=%0d dbz=%0b",
                       $realtime, want.screen_x, want.screen_y, want.div_by_zero,
                       got.screen_x, got.screen_y, got.div_by_zero);
          end
        end
      end
      if (s_tvalid && s_tready)
        projected_q.push_back(project_point(s_tdata[COORD_W-1:0],
                                            s_tdata[2*COORD_W-1:COORD_W],
                                            s_tdata[3*COORD_W-1:2*COORD_W]));
    end
    pending = projected_q.size();
  end

endmodule

FILE: dv/testbench.sv
// Top of the rotate_project_point testbench: clock, reset, stimulus, receiver and verdict.
`timescale 1ns / 100ps

module testbench;
  import rpp_pkg::*;

  localparam int FRAC        = COORD_FRAC_DEF;
  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_WAIT  = 40;
  localparam int HOLD_CYCLES = 400;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [3*COORD_W-1:0]   s_tdata;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [2*COORD_W-1:0]   m_tdata;
  logic                   m_tuser;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  int mismatches, pending, checked, zero_den_hits;
  int items_sent;
  int settings_used;
  int cycle_count;
  bit no_gaps;
  bit hold_off_req;

  rotate_project_point dut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata, .m_tuser,
    .cfg_we, .cfg_index, .cfg_data
  );

  rpp_checker #(.COORD_FRAC_BITS(FRAC)) u_checker (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata, .m_tuser,
    .cfg_we, .cfg_index, .cfg_data, .mismatches, .pending, .checked, .zero_den_hits
  );

  always #5 clk = ~clk;

  // Mostly back to back, sometimes short or long gaps
  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  // Trig value inside the unit range, or any 16-bit value
  function automatic logic [TRIG_W-1:0] rand_trig(input bit full_range);
    int v;
    if (full_range) return TRIG_W'($urandom);
    case ($urandom_range(0, 9))
      0:       v = 1 << TRIG_FRAC;
      1:       v = -(1 << TRIG_FRAC);
      2:       v = 0;
      default: v = int'($urandom_range(0, 2 << TRIG_FRAC)) - (1 << TRIG_FRAC);
    endcase
    return TRIG_W'(v);
  endfunction

  // Offer one point and hold it until accepted
  task automatic send_point(input logic [COORD_W-1:0] xp, input logic [COORD_W-1:0] yp,
                            input logic [COORD_W-1:0] zp);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata <= {zp, yp, xp};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop offering and wait until every result is back
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  // Load a full view setting; optionally hit the unused indexes too
  task automatic load_view(input logic [TRIG_W-1:0] ys, input logic [TRIG_W-1:0] yc,
                           input logic [TRIG_W-1:0] ps, input logic [TRIG_W-1:0] pc,
                           input logic [FOV_W-1:0] fov, input bit stray);
    write_reg(REG_YAW_SIN, ys);
    write_reg(REG_YAW_COS, yc);
    write_reg(REG_PITCH_SIN, ps);
    write_reg(REG_PITCH_COS, pc);
    write_reg(REG_VIEW_DIST, CFG_DATA_W'(fov));
    if (stray)
      for (int k = 1; k <= 3; k++)
        write_reg(CFG_IDX_W'(REG_VIEW_DIST) + CFG_IDX_W'(k), CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    int r, len;
    m_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_tready <= 1'b0;
        len = HOLD_CYCLES;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          m_tready <= 1'b1;
          len = $urandom_range(1, 40);
        end else if (r < 88) begin
          m_tready <= 1'b0;
          len = $urandom_range(1, 3);
        end else if (r < 98) begin
          m_tready <= 1'b0;
          len = $urandom_range(4, 25);
        end else begin
          m_tready <= 1'b0;
          len = $urandom_range(40, 80);
        end
      end
      // Cut the stretch short when a hold-off is requested
      for (int c = 0; c < len && !hold_off_req; c++) @(posedge clk);
    end
  end

  // Give up if the run hangs
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("testbench: errors");
    $finish;
  end

  // Stimulus and verdict
  initial begin
    int kind, r, fov_i;
    logic [TRIG_W-1:0] ys, yc, ps, pc;
    logic [FOV_W-1:0] fov;
    logic [COORD_W-1:0] xp, yp, zp;

    items_sent = 0;
    settings_used = 0;
    no_gaps = 1'b0;
    hold_off_req = 1'b0;
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset view: coordinate extremes, zero denominator at z = fov*16, its neighbors
    send_point(16'sd0, 16'sd0, 16'sd0);
    send_point(16'sd32767, 16'sd32767, 16'sd32767);
    send_point(-16'sd32768, -16'sd32768, -16'sd32768);
    send_point(16'sd32767, -16'sd32768, 16'sd0);
    send_point(-16'sd32768, 16'sd32767, 16'sd0);
    send_point(16'sd0, 16'sd0, 16'sd2800);
    send_point(16'sd100, -16'sd50, 16'sd2800);
    send_point(-16'sd3000, 16'sd2000, 16'sd2800);
    send_point(16'sd16, 16'sd16, 16'sd2799);
    send_point(16'sd16, 16'sd16, 16'sd2801);
    send_point(-16'sd16, 16'sd32, -16'sd16);
    wait_drained();

    // Trig values past the unit range, widest view distance
    load_view(-16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768, 10'd1023, 1'b0);
    send_point(16'sd32767, 16'sd32767, -16'sd32768);
    send_point(-16'sd32768, 16'sd0, 16'sd32767);
    send_point(16'sd1, -16'sd1, 16'sd1);
    send_point(16'sd0, 16'sd0, 16'sd0);
    wait_drained();

    // View distance of zero
    load_view(16'sd16384, -16'sd16384, -16'sd16384, 16'sd16384, 10'd0, 1'b0);
    send_point(16'sd32767, -16'sd32768, 16'sd32767);
    send_point(-16'sd32768, -16'sd32768, -16'sd32768);
    send_point(16'sd0, 16'sd0, 16'sd0);
    wait_drained();

    // Smallest nonzero distance, flipped pitch, writes to unused indexes must not stick
    load_view(16'sd0, 16'sd16384, 16'sd0, -16'sd16384, 10'd1, 1'b1);
    send_point(16'sd0, 16'sd0, -16'sd16);
    send_point(16'sd32767, 16'sd32767, -16'sd16);
    send_point(16'sd5, -16'sd7, -16'sd15);
    send_point(-16'sd32768, 16'sd32767, 16'sd32767);
    wait_drained();

    // Random phases, each under a fresh view setting
    for (int phase = 0; phase < 9; phase++) begin
      kind = (phase == 0) ? 0 : (phase == 2) ? 2 : $urandom_range(0, 2);
      r = $urandom_range(0, 9);
      fov = (r == 0) ? 10'd1 : (r == 1) ? 10'd1023 : (r == 2) ? 10'd0
          : FOV_W'($urandom_range(1, 1023));
      ys = rand_trig(kind == 2);
      yc = rand_trig(kind == 2);
      if (kind == 0) begin
        // Level pitch, so a known z lands on a zero denominator
        ps = '0;
        pc = $urandom_range(0, 1) ? TRIG_W'(1 << TRIG_FRAC) : TRIG_W'(-(1 << TRIG_FRAC));
      end else begin
        ps = rand_trig(kind == 2);
        pc = rand_trig(kind == 2);
      end
      load_view(ys, yc, ps, pc, fov, $urandom_range(0, 3) == 0);
      no_gaps = (phase == 1 || phase == 5);
      if (phase == 1) hold_off_req = 1'b1;
      for (int n = 0; n < 55; n++) begin
        r = $urandom_range(0, 9);
        if (r < 4) begin
          xp = COORD_W'($urandom);
          yp = COORD_W'($urandom);
          zp = COORD_W'($urandom);
        end else begin
          xp = COORD_W'(int'($urandom_range(0, 4096)) - 2048);
          yp = COORD_W'(int'($urandom_range(0, 4096)) - 2048);
          zp = COORD_W'(int'($urandom_range(0, 4096)) - 2048);
          if (r >= 8 && kind == 0) begin
            fov_i = int'(fov) << FRAC;
            zp = pc[TRIG_W-1] ? COORD_W'(-fov_i) : COORD_W'(fov_i);
          end
        end
        send_point(xp, yp, zp);
      end
      no_gaps = 1'b0;
      wait_drained();
    end

    repeat (DRAIN_WAIT) @(posedge clk);
    $display("summary: %0d points under %0d view settings, %0d projections checked",
             items_sent, settings_used + 1, checked);
    $display("summary: %0d zero denominators, %0d mismatches, %0d left unanswered",
             zero_den_hits, mismatches, pending);
    if (mismatches == 0 && pending == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/rpp_pkg.sv
design/rpp_front.sv
design/rpp_div.sv
design/rpp_outbuf.sv
design/rotate_project_point.sv
dv/rpp_checker.sv
dv/testbench.sv
